// ===== design/tesan_pkg.sv =====
// Shared types and constants for the terminal escape and UTF-8 sanitizer.
`default_nettype none

package tesan_pkg;

	// Most bytes one input item can produce
	localparam int unsigned MaxResults = 4;
	localparam int unsigned CountW     = $clog2(MaxResults + 1);
	localparam int unsigned IdxW       = $clog2(MaxResults);

	// Control codes
	localparam logic [7:0] EscCode = 8'h1B;
	localparam logic [7:0] BelCode = 8'h07;
	localparam logic [7:0] CanCode = 8'h18;
	localparam logic [7:0] SubCode = 8'h1A;
	localparam logic [7:0] LfCode  = 8'h0A;
	localparam logic [7:0] TabCode = 8'h09;
	localparam logic [7:0] DelCode = 8'h7F;
	localparam logic [7:0] C1Lo    = 8'h80;
	localparam logic [7:0] C1Hi    = 8'h9F;
	localparam logic [7:0] C1Ss2   = 8'h8E;
	localparam logic [7:0] C1Ss3   = 8'h8F;
	localparam logic [7:0] C1Dcs   = 8'h90;
	localparam logic [7:0] C1Csi   = 8'h9B;
	localparam logic [7:0] C1St    = 8'h9C;
	localparam logic [7:0] C1Osc   = 8'h9D;
	localparam logic [7:0] C1Pm    = 8'h9E;
	localparam logic [7:0] C1Apc   = 8'h9F;

	// Bytes produced by one item, handed from the step logic to the output buffer
	typedef struct packed {
		logic [MaxResults-1:0][7:0] bytes;
		logic [CountW-1:0]          count;
	} result_t;

endpackage

`default_nettype wire

// ===== design/terminal_escape_utf8_sanitizer_top.sv =====
// Top level of the terminal escape and UTF-8 sanitizer.
// One raw byte is taken per item and yields zero to four cleaned bytes, sent
// one per cycle while clean_ready is high, with last_of_run on the final byte
// of each item. Input items are accepted every cycle as long as the result
// buffer drains; an item that yields bytes holds back the next item until its
// final byte is taken. A byte enters an input register, is decoded against the
// mode and UTF-8 state combinationally once the result buffer is free, and its
// bytes are registered into the result buffer. Escape sequences, control codes
// and invalid UTF-8 are removed; newline and tab pass in normal mode only.
`default_nettype none

module terminal_escape_utf8_sanitizer_top (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       data_valid,
	output logic            data_ready,
	input  wire logic [7:0] data_byte,
	output logic            clean_valid,
	input  wire logic       clean_ready,
	output logic [7:0]      clean_byte,
	output logic            last_of_run
);

	logic               valid_s1;
	logic [7:0]         data_s1;
	logic               free;
	logic               fire;
	tesan_pkg::result_t res;

	// Process the held byte when the result buffer can take its bytes
	assign fire       = valid_s1 && free;
	assign data_ready = !valid_s1 || fire;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (data_valid && data_ready) begin
			valid_s1 <= 1'b1;
		end else if (fire) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (data_valid && data_ready) begin
			data_s1 <= data_byte;
		end
	end

	tesan_step u_step (
		.clk     (clk),
		.arst_n  (arst_n),
		.fire    (fire),
		.data_s1 (data_s1),
		.res     (res)
	);

	tesan_outbuf u_outbuf (
		.clk         (clk),
		.arst_n      (arst_n),
		.load        (fire),
		.res         (res),
		.free        (free),
		.clean_valid (clean_valid),
		.clean_ready (clean_ready),
		.clean_byte  (clean_byte),
		.last_of_run (last_of_run)
	);

	// A held byte that is not processed stays put
	a_hold_s1: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !fire |=> valid_s1 && $stable(data_s1))
		else $error("input register lost an item");

endmodule

`default_nettype wire

// ===== design/tesan_step.sv =====
// Terminal mode and UTF-8 gather state with the per-byte decode logic.
`default_nettype none

module tesan_step (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             fire,
	input  wire logic [7:0]       data_s1,
	output tesan_pkg::result_t    res
);

	typedef enum logic [2:0] {
		MODE_NORMAL  = 3'd0,
		MODE_ESC     = 3'd1,
		MODE_CSI     = 3'd2,
		MODE_STRING  = 3'd3,
		MODE_STR_ESC = 3'd4,
		MODE_SKIP    = 3'd5
	} mode_t;

	typedef struct packed {
		mode_t mode;
		logic  pass;
	} clean_t;

	mode_t             mode_q, mode_d;
	logic [1:0]        rem_q, rem_d;
	logic [2:0]        cnt_q, cnt_d;
	logic [20:0]       val_q, val_d;
	logic [3:0][7:0]   held_q, held_d;

	// C1 control, raw or decoded: may change the mode
	function automatic mode_t take_c1(input mode_t m, input logic [7:0] c);
		mode_t r;
		r = MODE_NORMAL;
		if (m == MODE_STRING || m == MODE_STR_ESC) begin
			r = (c == tesan_pkg::C1St) ? MODE_NORMAL : MODE_STRING;
		end else if (c == tesan_pkg::C1Csi) begin
			r = MODE_CSI;
		end else if (c == tesan_pkg::C1Dcs || c == tesan_pkg::C1Osc ||
			     c == tesan_pkg::C1Pm || c == tesan_pkg::C1Apc) begin
			r = MODE_STRING;
		end else if (c == tesan_pkg::C1Ss2 || c == tesan_pkg::C1Ss3) begin
			r = MODE_SKIP;
		end
		return r;
	endfunction

	// Range checks on a completed code point
	function automatic logic cp_ok(input logic [20:0] cp, input logic [2:0] len);
		logic [20:0] lo;
		logic        ok;
		ok = 1'b1;
		lo = 21'h0;
		case (len)
			3'd2:    lo = 21'h80;
			3'd3:    lo = 21'h800;
			3'd4:    lo = 21'h10000;
			default: ok = 1'b0;
		endcase
		if (cp < lo) ok = 1'b0;
		if (cp >= 21'hD800 && cp <= 21'hDFFF) ok = 1'b0;
		if (cp > 21'h10FFFF) ok = 1'b0;
		return ok;
	endfunction

	// Terminal mode handling of one byte outside a UTF-8 gather
	function automatic clean_t clean_char(input mode_t m, input logic [7:0] c);
		clean_t r;
		r.mode = m;
		r.pass = 1'b0;
		if (m == MODE_SKIP) begin
			r.mode = MODE_NORMAL;
		end else if (c == tesan_pkg::CanCode || c == tesan_pkg::SubCode) begin
			r.mode = MODE_NORMAL;
		end else if (c == tesan_pkg::EscCode) begin
			r.mode = (m == MODE_STRING || m == MODE_STR_ESC) ? MODE_STR_ESC : MODE_ESC;
		end else if (c == tesan_pkg::BelCode) begin
			if (m == MODE_STRING || m == MODE_STR_ESC) r.mode = MODE_NORMAL;
		end else if (c == tesan_pkg::LfCode || c == tesan_pkg::TabCode) begin
			r.pass = (m == MODE_NORMAL);
		end else if (c < 8'h20 || c == tesan_pkg::DelCode) begin
			r.pass = 1'b0;
		end else if (c >= tesan_pkg::C1Lo && c <= tesan_pkg::C1Hi) begin
			r.mode = take_c1(m, c);
		end else begin
			unique case (m)
				MODE_NORMAL: r.pass = 1'b1;
				MODE_ESC: begin
					case (c) inside
						8'h5B:                      r.mode = MODE_CSI;
						8'h5D, 8'h50, 8'h5E, 8'h5F: r.mode = MODE_STRING;
						8'h4E, 8'h4F, 8'h23, 8'h25, 8'h20, 8'h28, 8'h29,
						8'h2A, 8'h2B, 8'h2D, 8'h2E, 8'h2F:
							r.mode = MODE_SKIP;
						default:                    r.mode = MODE_NORMAL;
					endcase
				end
				MODE_CSI: begin
					if (c >= 8'h40 && c <= 8'h7E) r.mode = MODE_NORMAL;
				end
				MODE_STRING:  r.mode = MODE_STRING;
				MODE_STR_ESC: r.mode = (c == 8'h5C) ? MODE_NORMAL : MODE_STRING;
				MODE_SKIP:    r.mode = MODE_NORMAL;
				default:      r.mode = MODE_NORMAL;
			endcase
		end
		return r;
	endfunction

	// Decode one byte against the current state
	always_comb begin
		logic            afresh;
		logic [3:0][7:0] held_a;
		logic [20:0]     acc_val;
		logic [1:0]      rem_m;
		logic [2:0]      len;
		clean_t          cc;

		mode_d  = mode_q;
		rem_d   = rem_q;
		cnt_d   = cnt_q;
		val_d   = val_q;
		held_d  = held_q;
		res     = '0;
		afresh  = 1'b1;
		held_a  = held_q;
		held_a[cnt_q[1:0]] = data_s1;
		acc_val = {val_q[14:0], data_s1[5:0]};
		rem_m   = rem_q - 2'd1;
		len     = cnt_q + 3'd1;
		cc      = clean_char(mode_q, data_s1);

		if (rem_q != 2'd0) begin
			if (data_s1[7:6] != 2'b10) begin
				// bad continuation: drop the gather, then handle the byte afresh
				rem_d  = '0;
				cnt_d  = '0;
				val_d  = '0;
				held_d = '0;
			end else if (cnt_q[2]) begin
				// gather overflow: drop the gather and the byte
				afresh = 1'b0;
				rem_d  = '0;
				cnt_d  = '0;
				val_d  = '0;
				held_d = '0;
			end else begin
				afresh = 1'b0;
				if (rem_m != 2'd0) begin
					rem_d  = rem_m;
					cnt_d  = len;
					val_d  = acc_val;
					held_d = held_a;
				end else begin
					rem_d  = '0;
					cnt_d  = '0;
					val_d  = '0;
					held_d = '0;
					if (cp_ok(acc_val, len)) begin
						if (acc_val >= 21'(tesan_pkg::C1Lo) &&
						    acc_val <= 21'(tesan_pkg::C1Hi)) begin
							mode_d = take_c1(mode_q, acc_val[7:0]);
						end else begin
							res.bytes = held_a;
							res.count = len;
						end
					end
				end
			end
		end

		if (afresh) begin
			if (mode_q == MODE_NORMAL && data_s1[7]) begin
				if (data_s1 <= tesan_pkg::C1Hi) begin
					mode_d = take_c1(mode_q, data_s1);
				end else if (data_s1 >= 8'hC2 && data_s1 <= 8'hDF) begin
					rem_d     = 2'd1;
					cnt_d     = 3'd1;
					val_d     = {16'h0, data_s1[4:0]};
					held_d[0] = data_s1;
				end else if (data_s1 >= 8'hE0 && data_s1 <= 8'hEF) begin
					rem_d     = 2'd2;
					cnt_d     = 3'd1;
					val_d     = {17'h0, data_s1[3:0]};
					held_d[0] = data_s1;
				end else if (data_s1 >= 8'hF0 && data_s1 <= 8'hF4) begin
					rem_d     = 2'd3;
					cnt_d     = 3'd1;
					val_d     = {18'h0, data_s1[2:0]};
					held_d[0] = data_s1;
				end
			end else begin
				mode_d = cc.mode;
				if (cc.pass) begin
					res.bytes[0] = data_s1;
					res.count    = tesan_pkg::CountW'(1);
				end
			end
		end
	end

	// Advance state on each processed item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_NORMAL;
			rem_q  <= '0;
			cnt_q  <= '0;
			val_q  <= '0;
			held_q <= '0;
		end else if (fire) begin
			mode_q <= mode_d;
			rem_q  <= rem_d;
			cnt_q  <= cnt_d;
			val_q  <= val_d;
			held_q <= held_d;
		end
	end

	// A pending gather holds the lead and expects a total of two to four bytes
	a_gather_len: assert property (@(posedge clk) disable iff (!arst_n)
		rem_q != 2'd0 |-> ({1'b0, cnt_q} + {2'b0, rem_q}) >= 4'd2 &&
		                  ({1'b0, cnt_q} + {2'b0, rem_q}) <= 4'd4)
		else $error("UTF-8 gather length out of range");

	a_idle_gather: assert property (@(posedge clk) disable iff (!arst_n)
		rem_q == 2'd0 |-> cnt_q == 3'd0 && val_q == 21'd0)
		else $error("stale UTF-8 gather state");

	// Only a gather of at least two bytes emits more than one byte
	a_multi_needs_gather: assert property (@(posedge clk) disable iff (!arst_n)
		fire && res.count > 1 |-> rem_q == 2'd1 && cnt_q != 3'd0)
		else $error("multi-byte result without a completed gather");

endmodule

`default_nettype wire

// ===== design/tesan_outbuf.sv =====
// Result buffer that hands out the bytes of one item, one per cycle while the receiver is ready.
`default_nettype none

module tesan_outbuf (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             load,
	input  wire tesan_pkg::result_t res,
	output logic                  free,
	output logic                  clean_valid,
	input  wire logic             clean_ready,
	output logic [7:0]            clean_byte,
	output logic                  last_of_run
);

	logic [tesan_pkg::MaxResults-1:0][7:0] bytes_q;
	logic [tesan_pkg::CountW-1:0]          count_q;
	logic [tesan_pkg::IdxW-1:0]            idx_q;
	logic                                  take;

	// Present the current byte and mark the last of the item
	assign clean_valid = (count_q != '0);
	assign clean_byte  = bytes_q[idx_q];
	assign last_of_run = ({1'b0, idx_q} == count_q - tesan_pkg::CountW'(1));
	assign take        = clean_valid && clean_ready;
	assign free        = !clean_valid || (take && last_of_run);

	// Track how many bytes remain and which one is next
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			idx_q   <= '0;
		end else if (load) begin
			count_q <= res.count;
			idx_q   <= '0;
		end else if (take) begin
			if (last_of_run) begin
				count_q <= '0;
				idx_q   <= '0;
			end else begin
				idx_q <= idx_q + tesan_pkg::IdxW'(1);
			end
		end
	end

	// Hold the bytes of the item being sent
	always_ff @(posedge clk) begin
		if (load) begin
			bytes_q <= res.bytes;
		end
	end

	a_idx_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q != '0 |-> {1'b0, idx_q} < count_q)
		else $error("output index beyond byte count");

endmodule

`default_nettype wire

// ===== test/sanitizer_checker.sv =====
// Checker for the terminal sanitizer: predicts cleaned bytes and compares them on the output channel.
`timescale 1ns / 1ps

module sanitizer_checker (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       data_valid,
	input  wire logic       data_ready,
	input  wire logic [7:0] data_byte,
	input  wire logic       clean_valid,
	input  wire logic       clean_ready,
	input  wire logic [7:0] clean_byte,
	input  wire logic       last_of_run,
	output int unsigned     fail_count,
	output int unsigned     pending_count
);

	typedef enum logic [2:0] {
		ModeNormal = 3'd0,
		ModeEsc    = 3'd1,
		ModeCsi    = 3'd2,
		ModeString = 3'd3,
		ModeStrEsc = 3'd4,
		ModeSkip   = 3'd5
	} term_mode_t;

	typedef struct packed {
		logic [7:0] value;
		logic       last;
	} clean_out_t;

	// Predicted terminal and UTF-8 gather state
	term_mode_t  mode;
	logic [1:0]  seq_left;
	logic [2:0]  seq_count;
	logic [20:0] seq_value;
	logic [7:0]  seq_held [4];

	clean_out_t  clean_expected [$];
	int unsigned mismatches = 0;

	function automatic logic in_string();
		return mode == ModeString || mode == ModeStrEsc;
	endfunction

	task automatic clear_seq();
		seq_left  = '0;
		seq_count = '0;
		seq_value = '0;
		foreach (seq_held[i]) seq_held[i] = '0;
	endtask

	// C1 control, raw or decoded from UTF-8: always dropped, may switch mode
	task automatic apply_c1(input logic [7:0] c);
		if (in_string()) begin
			mode = (c == tesan_pkg::C1St) ? ModeNormal : ModeString;
		end else begin
			case (c)
				tesan_pkg::C1Csi: mode = ModeCsi;
				tesan_pkg::C1Dcs, tesan_pkg::C1Osc, tesan_pkg::C1Pm, tesan_pkg::C1Apc:
					mode = ModeString;
				tesan_pkg::C1Ss2, tesan_pkg::C1Ss3: mode = ModeSkip;
				default:                            mode = ModeNormal;
			endcase
		end
	endtask

	// Advance the predicted state by one raw byte and queue the bytes it yields
	task automatic sanitize_byte(input logic [7:0] c);
		logic [2:0]  len;
		logic [20:0] cp;
		logic [20:0] lo;
		logic [7:0]  held [4];
		logic        pass;
		pass = 1'b0;

		// Gather a pending UTF-8 sequence
		if (seq_left != 0) begin
			if (c < 8'h80 || c > 8'hBF) begin
				// bad continuation: discard, then treat the byte as new
				clear_seq();
			end else if (seq_count >= 3'd4) begin
				clear_seq();
				return;
			end else begin
				seq_held[seq_count[1:0]] = c;
				seq_count = seq_count + 3'd1;
				seq_value = {seq_value[14:0], c[5:0]};
				seq_left  = seq_left - 2'd1;
				if (seq_left != 0) return;
				len  = seq_count;
				cp   = seq_value;
				held = seq_held;
				clear_seq();
				case (len)
					3'd2:    lo = 21'h80;
					3'd3:    lo = 21'h800;
					3'd4:    lo = 21'h10000;
					default: return;
				endcase
				// drop overlong forms, surrogates and values past the last plane
				if (cp < lo || (cp >= 21'hD800 && cp <= 21'hDFFF) || cp > 21'h10FFFF) return;
				if (cp >= 21'(tesan_pkg::C1Lo) && cp <= 21'(tesan_pkg::C1Hi)) begin
					apply_c1(cp[7:0]);
					return;
				end
				for (int k = 0; k < len; k++) begin
					clean_expected.push_back('{value: held[k], last: (k + 1 == len)});
				end
				return;
			end
		end

		// High bytes in normal mode: C1 controls or UTF-8 leads
		if (mode == ModeNormal && c >= 8'h80) begin
			if (c <= tesan_pkg::C1Hi) begin
				apply_c1(c);
			end else if (c >= 8'hC2 && c <= 8'hDF) begin
				seq_left  = 2'd1;
				seq_count = 3'd1;
				seq_value = {16'b0, c[4:0]};
				seq_held[0] = c;
			end else if (c >= 8'hE0 && c <= 8'hEF) begin
				seq_left  = 2'd2;
				seq_count = 3'd1;
				seq_value = {17'b0, c[3:0]};
				seq_held[0] = c;
			end else if (c >= 8'hF0 && c <= 8'hF4) begin
				seq_left  = 2'd3;
				seq_count = 3'd1;
				seq_value = {18'b0, c[2:0]};
				seq_held[0] = c;
			end
			return;
		end

		// Terminal mode handling for single bytes
		if (mode == ModeSkip) begin
			mode = ModeNormal;
		end else if (c == tesan_pkg::CanCode || c == tesan_pkg::SubCode) begin
			mode = ModeNormal;
		end else if (c == tesan_pkg::EscCode) begin
			mode = in_string() ? ModeStrEsc : ModeEsc;
		end else if (c == tesan_pkg::BelCode) begin
			if (in_string()) mode = ModeNormal;
		end else if (c == tesan_pkg::LfCode || c == tesan_pkg::TabCode) begin
			pass = (mode == ModeNormal);
		end else if (c < 8'h20 || c == tesan_pkg::DelCode) begin
			pass = 1'b0;
		end else if (c >= tesan_pkg::C1Lo && c <= tesan_pkg::C1Hi) begin
			apply_c1(c);
		end else begin
			case (mode)
				ModeNormal: pass = 1'b1;
				ModeEsc: begin
					mode = ModeNormal;
					case (c)
						"[":                mode = ModeCsi;
						"]", "P", "^", "_": mode = ModeString;
						"N", "O", "#", "%", " ", "(", ")", "*", "+", "-", ".", "/":
							mode = ModeSkip;
						default: ;
					endcase
				end
				ModeCsi: begin
					if (c >= 8'h40 && c <= 8'h7E) mode = ModeNormal;
				end
				ModeString: pass = 1'b0;
				ModeStrEsc: mode = (c == "\\") ? ModeNormal : ModeString;
				default:    mode = ModeNormal;
			endcase
		end

		if (pass) clean_expected.push_back('{value: c, last: 1'b1});
	endtask

	// Compare outputs first, then predict from the input taken at the same edge
	always @(posedge clk or negedge arst_n) begin
		clean_out_t want;
		if (!arst_n) begin
			mode = ModeNormal;
			clear_seq();
			clean_expected.delete();
		end else begin
			if (clean_valid && clean_ready) begin
				if (clean_expected.size() == 0) begin
					$error("clean_byte: unexpected output %02h with nothing expected", clean_byte);
					mismatches++;
				end else begin
					want = clean_expected.pop_front();
					if (clean_byte !== want.value) begin
						$error("clean_byte: expected %02h, actual %02h", want.value, clean_byte);
						mismatches++;
					end
					if (last_of_run !== want.last) begin
						$error("last_of_run: expected %0b, actual %0b", want.last, last_of_run);
						mismatches++;
					end
				end
			end
			if (data_valid && data_ready) sanitize_byte(data_byte);
		end
		fail_count    <= mismatches;
		pending_count <= clean_expected.size();
	end

endmodule

// ===== test/tb.sv =====
// Top of the sanitizer testbench: clock, reset, byte stream stimulus and the verdict.
`timescale 1ns / 1ps

module tb;

	localparam int unsigned PhaseItems  = 96;
	localparam int unsigned SettleTicks = 8;
	localparam int unsigned IdleLimit   = 2000;

	typedef enum int {
		TokText,
		TokLine,
		TokUtf8,
		TokCsi,
		TokString,
		TokDesignator,
		TokEncodedC1,
		TokBrokenUtf8,
		TokNoise
	} token_t;

	// Hand-picked opening stream: extremes, controls, sequences and UTF-8 corner cases
	localparam logic [7:0] OpeningBytes [26] = '{
		8'h41, 8'h00, tesan_pkg::LfCode, tesan_pkg::TabCode, tesan_pkg::DelCode,
		tesan_pkg::EscCode, "[", "1", "m",
		8'hC3, 8'hA9,
		8'hF4, 8'h8F, 8'hBF, 8'hBF,
		8'hED, 8'hA0, 8'h80,
		8'hC2, tesan_pkg::C1Csi, "A",
		8'hE2, "A",
		8'hFF,
		tesan_pkg::C1Osc, tesan_pkg::BelCode
	};
	localparam logic [7:0] StringIntro [4] = '{"]", "P", "^", "_"};
	localparam logic [7:0] StringC1 [4]    = '{
		tesan_pkg::C1Osc, tesan_pkg::C1Dcs, tesan_pkg::C1Pm, tesan_pkg::C1Apc
	};
	localparam logic [7:0] Designators [12] = '{
		"N", "O", "#", "%", " ", "(", ")", "*", "+", "-", ".", "/"
	};

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        data_valid = 1'b0;
	logic        data_ready;
	logic [7:0]  data_byte = 8'h00;
	logic        clean_valid;
	logic        clean_ready = 1'b0;
	logic [7:0]  clean_byte;
	logic        last_of_run;
	int unsigned fail_count;
	int unsigned pending_count;

	int unsigned send_idle_pct = 0;
	int unsigned recv_stall_pct = 0;
	int unsigned quiet_cycles = 0;
	logic [7:0]  burst [$];

	always #5 clk = ~clk;

	terminal_escape_utf8_sanitizer_top u_top (
		.clk         (clk),
		.arst_n      (arst_n),
		.data_valid  (data_valid),
		.data_ready  (data_ready),
		.data_byte   (data_byte),
		.clean_valid (clean_valid),
		.clean_ready (clean_ready),
		.clean_byte  (clean_byte),
		.last_of_run (last_of_run)
	);

	sanitizer_checker u_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.data_valid    (data_valid),
		.data_ready    (data_ready),
		.data_byte     (data_byte),
		.clean_valid   (clean_valid),
		.clean_ready   (clean_ready),
		.clean_byte    (clean_byte),
		.last_of_run   (last_of_run),
		.fail_count    (fail_count),
		.pending_count (pending_count)
	);

	// Stall the output at random
	always @(posedge clk) begin
		clean_ready <= ($urandom_range(99) >= recv_stall_pct);
	end

	// End the run when nothing moves for too long
	always @(posedge clk) begin
		if ((data_valid && data_ready) || (clean_valid && clean_ready)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= IdleLimit) begin
				$display("Testbench completed WITH ERRORS");
				$finish;
			end
		end
	end

	// Offer one byte, with random idle cycles ahead of it, and hold it until taken
	task automatic send_byte(input logic [7:0] value);
		while ($urandom_range(99) < send_idle_pct) begin
			data_valid <= 1'b0;
			@(posedge clk);
		end
		data_valid <= 1'b1;
		data_byte  <= value;
		do @(posedge clk); while (!data_ready);
	endtask

	// Stop sending and let every predicted byte come out
	task automatic drain();
		data_valid <= 1'b0;
		repeat (2) @(posedge clk);
		while (pending_count != 0) @(posedge clk);
		repeat (SettleTicks) @(posedge clk);
	endtask

	task automatic push_printable();
		burst.push_back(8'($urandom_range(8'h20, 8'h7E)));
	endtask

	// Build one token of text: mostly well-formed sequences, some broken ones and noise
	task automatic build_burst();
		int unsigned pick;
		int unsigned len;
		logic [20:0] cp;
		token_t      kind;
		burst.delete();
		pick = $urandom_range(99);
		if (pick < 25)      kind = TokText;
		else if (pick < 30) kind = TokLine;
		else if (pick < 50) kind = TokUtf8;
		else if (pick < 60) kind = TokCsi;
		else if (pick < 68) kind = TokString;
		else if (pick < 73) kind = TokDesignator;
		else if (pick < 78) kind = TokEncodedC1;
		else if (pick < 88) kind = TokBrokenUtf8;
		else                kind = TokNoise;

		case (kind)
			TokText: begin
				repeat ($urandom_range(1, 4)) push_printable();
			end
			TokLine: begin
				burst.push_back($urandom_range(1) ? tesan_pkg::LfCode : tesan_pkg::TabCode);
			end
			TokUtf8: begin
				len = $urandom_range(2, 4);
				case (len)
					2: begin
						cp = 21'($urandom_range(21'h80, 21'h7FF));
						burst.push_back({3'b110, cp[10:6]});
					end
					3: begin
						cp = 21'($urandom_range(21'h800, 21'hFFFF));
						burst.push_back({4'b1110, cp[15:12]});
						burst.push_back({2'b10, cp[11:6]});
					end
					default: begin
						cp = 21'($urandom_range(21'h10000, 21'h10FFFF));
						burst.push_back({5'b11110, cp[20:18]});
						burst.push_back({2'b10, cp[17:12]});
						burst.push_back({2'b10, cp[11:6]});
					end
				endcase
				burst.push_back({2'b10, cp[5:0]});
			end
			TokCsi: begin
				if ($urandom_range(3) == 0) begin
					burst.push_back(tesan_pkg::C1Csi);
				end else begin
					burst.push_back(tesan_pkg::EscCode);
					burst.push_back("[");
				end
				repeat ($urandom_range(0, 3)) burst.push_back(8'($urandom_range(8'h30, 8'h3F)));
				if ($urandom_range(3) == 0) burst.push_back(8'($urandom_range(8'h20, 8'h2F)));
				burst.push_back(8'($urandom_range(8'h40, 8'h7E)));
				push_printable();
			end
			TokString: begin
				if ($urandom_range(3) == 0) begin
					burst.push_back(StringC1[$urandom_range(3)]);
				end else begin
					burst.push_back(tesan_pkg::EscCode);
					burst.push_back(StringIntro[$urandom_range(3)]);
				end
				repeat ($urandom_range(0, 5)) burst.push_back(8'($urandom_range(8'h20, 8'hFF)));
				case ($urandom_range(2))
					0: burst.push_back(tesan_pkg::BelCode);
					1: burst.push_back(tesan_pkg::C1St);
					default: begin
						burst.push_back(tesan_pkg::EscCode);
						burst.push_back("\\");
					end
				endcase
				push_printable();
			end
			TokDesignator: begin
				burst.push_back(tesan_pkg::EscCode);
				burst.push_back(Designators[$urandom_range(11)]);
				burst.push_back(8'($urandom_range(8'h20, 8'hFF)));
				push_printable();
			end
			TokEncodedC1: begin
				burst.push_back(8'hC2);
				burst.push_back(8'($urandom_range(tesan_pkg::C1Lo, tesan_pkg::C1Hi)));
				push_printable();
			end
			TokBrokenUtf8: begin
				case ($urandom_range(4))
					0: begin
						// lead cut short by a non-continuation byte
						burst.push_back(8'($urandom_range(8'hC2, 8'hF4)));
						burst.push_back(8'($urandom_range(8'h00, 8'h7F)));
					end
					1: begin
						// overlong two-byte form
						burst.push_back(8'($urandom_range(8'hC0, 8'hC1)));
						burst.push_back(8'($urandom_range(8'h80, 8'hBF)));
					end
					2: begin
						// overlong three-byte form
						burst.push_back(8'hE0);
						burst.push_back(8'($urandom_range(8'h80, 8'h9F)));
						burst.push_back(8'($urandom_range(8'h80, 8'hBF)));
					end
					3: begin
						// surrogate half
						burst.push_back(8'hED);
						burst.push_back(8'($urandom_range(8'hA0, 8'hBF)));
						burst.push_back(8'($urandom_range(8'h80, 8'hBF)));
					end
					default: begin
						// four-byte form that may be past the last plane, overlong or valid
						burst.push_back($urandom_range(1) ? 8'hF4 : 8'hF0);
						burst.push_back(8'($urandom_range(8'h80, 8'hBF)));
						burst.push_back(8'($urandom_range(8'h80, 8'hBF)));
						burst.push_back(8'($urandom_range(8'h80, 8'hBF)));
					end
				endcase
				push_printable();
			end
			default: begin
				repeat ($urandom_range(1, 3)) burst.push_back(8'($urandom_range(8'h00, 8'hFF)));
			end
		endcase
	endtask

	initial begin
		int unsigned sent;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (OpeningBytes[i]) send_byte(OpeningBytes[i]);
		drain();

		// Random traffic under each idle and stall mix, draining between mixes
		for (int phase = 0; phase < 4; phase++) begin
			case (phase)
				0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
				1:       begin send_idle_pct = 68; recv_stall_pct = 0;  end
				2:       begin send_idle_pct = 0;  recv_stall_pct = 68; end
				default: begin send_idle_pct = 29; recv_stall_pct = 29; end
			endcase
			sent = 0;
			while (sent < PhaseItems) begin
				build_burst();
				foreach (burst[i]) send_byte(burst[i]);
				sent += burst.size();
			end
			drain();
		end

		if (fail_count == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule
